FILE: hw/rtl/dlts_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the delta list task scheduler
package dlts_pkg;

  localparam logic [1:0] CMD_TICK     = 2'd0;
  localparam logic [1:0] CMD_ADD      = 2'd1;
  localparam logic [1:0] CMD_DISPATCH = 2'd2;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  task_id;
    logic [15:0] first_delay;
    logic [15:0] repeat_period;
  } in_t;

  typedef struct packed {
    logic       fired;
    logic [7:0] fired_task;
    logic       add_dropped;
    logic       tail_lost;
    logic       head_ready;
    logic       list_empty;
  } out_t;

  typedef struct packed {
    logic [7:0]  task_id;
    logic [15:0] delta;
    logic [15:0] period;
    logic        ready;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

FILE: hw/rtl/delta_list_task_scheduler_core.sv
`timescale 1ns / 1ps
// delta list task scheduler: sequencer, entry ram and shared alu
//
//  channel | ports                     | transfer when
//  --------+---------------------------+------------------------------
//  input   | start, busy, in_data      | start high while busy low
//  result  | out_valid, out_data       | out_valid high, one cycle only
//
// a tick, or a dispatch with no ready head, reads and checks the head and then
// reads it again for the result; command 3 does only that last read. a dispatch
// that removes the head moves each later entry up one place, then runs an add
// for a periodic task. an add walks the entries to its place, then shifts the
// later entries down unless it appends; all steps share the one entry ram.
// the result strobe is high in the first cycle that busy is low; a new start
// may be taken in that same cycle. the receiver cannot stall the result.
// reset is synchronous; the fill count empties the list, no clearing pass.
module delta_list_task_scheduler_core
  import dlts_pkg::*;
#(
  parameter int MAX_TASKS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  localparam int IW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam logic [CW-1:0] FULL = CW'(MAX_TASKS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_HEAD_RD,
    S_HEAD_CHK,
    S_RM_RD,
    S_RM_WR,
    S_WALK_RD,
    S_WALK_CHK,
    S_SH_CHK,
    S_SH_WR,
    S_INS_WR,
    S_FIN_RD,
    S_FIN_CHK
  } state_t;

  state_t         state_r, state_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           out_valid_r, out_valid_nxt;
  out_t           out_data_r, out_data_nxt;
  logic [1:0]     cmd_r, cmd_nxt;
  logic [7:0]     id_r, id_nxt;
  logic [15:0]    dly_r, dly_nxt;
  logic [15:0]    per_r, per_nxt;
  logic [15:0]    sum_r, sum_nxt;
  logic [16:0]    sum_hit_r, sum_hit_nxt;
  logic [CW-1:0]  i_r, i_nxt;
  logic [IW-1:0]  j_r, j_nxt;
  logic [IW-1:0]  ins_r, ins_nxt;
  entry_t         disp_r, disp_nxt;
  logic           fired_r, fired_nxt;
  logic [7:0]     ftask_r, ftask_nxt;
  logic           dropped_r, dropped_nxt;
  logic           lost_r, lost_nxt;

  logic               we;
  logic [IW-1:0]      waddr;
  entry_t             wdata;
  logic [IW-1:0]      raddr;
  logic [ENTRY_W-1:0] rd_word;
  entry_t             rd_ent;
  logic [IW-1:0]      diff;

  alu_op_t     alu_op;
  logic [16:0] alu_a;
  logic [16:0] alu_b;
  logic [16:0] alu_res;
  logic        alu_gt;

  assign rd_ent = rd_word;
  assign diff   = j_r - ins_r;

  dlts_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_TASKS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_word)
  );

  dlts_alu u_alu (
    .op     (alu_op),
    .a      (alu_a),
    .b      (alu_b),
    .lim    (dly_r),
    .res    (alu_res),
    .gt_lim (alu_gt)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    cmd_nxt       = cmd_r;
    id_nxt        = id_r;
    dly_nxt       = dly_r;
    per_nxt       = per_r;
    sum_nxt       = sum_r;
    sum_hit_nxt   = sum_hit_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    ins_nxt       = ins_r;
    disp_nxt      = disp_r;
    fired_nxt     = fired_r;
    ftask_nxt     = ftask_r;
    dropped_nxt   = dropped_r;
    lost_nxt      = lost_r;
    we            = 1'b0;
    waddr         = '0;
    wdata         = '0;
    raddr         = '0;
    alu_op        = ALU_ADD;
    alu_a         = '0;
    alu_b         = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt     = in_data.command;
          id_nxt      = in_data.task_id;
          dly_nxt     = in_data.first_delay;
          per_nxt     = in_data.repeat_period;
          fired_nxt   = 1'b0;
          ftask_nxt   = '0;
          dropped_nxt = 1'b0;
          lost_nxt    = 1'b0;
          sum_nxt     = '0;
          i_nxt       = '0;
          case (in_data.command)
            CMD_ADD:      state_nxt = S_WALK_RD;
            CMD_TICK:     state_nxt = S_HEAD_RD;
            CMD_DISPATCH: state_nxt = S_HEAD_RD;
            default:      state_nxt = S_FIN_RD;
          endcase
        end
      end

      S_HEAD_RD: begin
        state_nxt = S_HEAD_CHK;
      end

      S_HEAD_CHK: begin
        alu_op    = ALU_SUB;
        alu_a     = {1'b0, rd_ent.delta};
        alu_b     = 17'd1;
        state_nxt = S_FIN_RD;
        if (count_r != '0) begin
          if (cmd_r == CMD_TICK && !rd_ent.ready) begin
            we    = 1'b1;
            wdata = rd_ent;
            if (rd_ent.delta == '0) begin
              wdata.ready = 1'b1;
            end else begin
              wdata.delta = alu_res[15:0];
            end
          end else if (cmd_r == CMD_DISPATCH && rd_ent.ready) begin
            fired_nxt = 1'b1;
            ftask_nxt = rd_ent.task_id;
            id_nxt    = rd_ent.task_id;
            dly_nxt   = rd_ent.period;
            per_nxt   = rd_ent.period;
            j_nxt     = '0;
            if (count_r > CW'(1)) begin
              state_nxt = S_RM_RD;
            end else begin
              count_nxt = count_r - CW'(1);
              state_nxt = (rd_ent.period != '0) ? S_WALK_RD : S_FIN_RD;
            end
          end
        end
      end

      // move every entry up one place to drop the head
      S_RM_RD: begin
        raddr     = j_r + IW'(1);
        state_nxt = S_RM_WR;
      end

      S_RM_WR: begin
        we    = 1'b1;
        waddr = j_r;
        wdata = rd_ent;
        if (CW'(j_r) + CW'(2) == count_r) begin
          count_nxt = count_r - CW'(1);
          state_nxt = (per_r != '0) ? S_WALK_RD : S_FIN_RD;
        end else begin
          j_nxt     = j_r + IW'(1);
          state_nxt = S_RM_RD;
        end
      end

      S_WALK_RD: begin
        alu_op = ALU_SUB;
        alu_a  = {1'b0, dly_r};
        alu_b  = {1'b0, sum_r};
        if (i_r == count_r) begin
          // due after every entry: append or drop
          if (count_r == FULL) begin
            dropped_nxt = 1'b1;
          end else begin
            we            = 1'b1;
            waddr         = count_r[IW-1:0];
            wdata.task_id = id_r;
            wdata.delta   = alu_res[15:0];
            wdata.period  = per_r;
            wdata.ready   = (alu_res[15:0] == '0);
            count_nxt     = count_r + CW'(1);
          end
          state_nxt = S_FIN_RD;
        end else begin
          raddr     = i_r[IW-1:0];
          state_nxt = S_WALK_CHK;
        end
      end

      S_WALK_CHK: begin
        alu_op = ALU_ADD;
        alu_a  = {1'b0, sum_r};
        alu_b  = {1'b0, rd_ent.delta};
        if (alu_gt) begin
          sum_hit_nxt = alu_res;
          disp_nxt    = rd_ent;
          ins_nxt     = i_r[IW-1:0];
          if (count_r == FULL) begin
            j_nxt    = IW'(MAX_TASKS - 1);
            lost_nxt = 1'b1;
          end else begin
            j_nxt = count_r[IW-1:0];
          end
          state_nxt = S_SH_CHK;
        end else begin
          sum_nxt   = alu_res[15:0];
          i_nxt     = i_r + CW'(1);
          state_nxt = S_WALK_RD;
        end
      end

      // shift the tail down from the end toward the insertion point
      S_SH_CHK: begin
        alu_op = ALU_SUB;
        alu_a  = sum_hit_r;
        alu_b  = {1'b0, dly_r};
        if (diff > IW'(1)) begin
          raddr     = j_r - IW'(1);
          state_nxt = S_SH_WR;
        end else if (diff == IW'(1)) begin
          // displaced entry keeps what remains of its delta
          we          = 1'b1;
          waddr       = j_r;
          wdata       = disp_r;
          wdata.delta = alu_res[15:0];
          state_nxt   = S_INS_WR;
        end else begin
          state_nxt = S_INS_WR;
        end
      end

      S_SH_WR: begin
        we        = 1'b1;
        waddr     = j_r;
        wdata     = rd_ent;
        j_nxt     = j_r - IW'(1);
        state_nxt = S_SH_CHK;
      end

      S_INS_WR: begin
        alu_op        = ALU_SUB;
        alu_a         = {1'b0, dly_r};
        alu_b         = {1'b0, sum_r};
        we            = 1'b1;
        waddr         = ins_r;
        wdata.task_id = id_r;
        wdata.delta   = alu_res[15:0];
        wdata.period  = per_r;
        wdata.ready   = (alu_res[15:0] == '0);
        if (count_r != FULL) begin
          count_nxt = count_r + CW'(1);
        end
        state_nxt = S_FIN_RD;
      end

      S_FIN_RD: begin
        state_nxt = S_FIN_CHK;
      end

      S_FIN_CHK: begin
        out_valid_nxt           = 1'b1;
        out_data_nxt.fired      = fired_r;
        out_data_nxt.fired_task = ftask_r;
        out_data_nxt.add_dropped = dropped_r;
        out_data_nxt.tail_lost  = lost_r;
        out_data_nxt.head_ready = (count_r != '0) && rd_ent.ready;
        out_data_nxt.list_empty = (count_r == '0);
        state_nxt               = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    cmd_r      <= cmd_nxt;
    id_r       <= id_nxt;
    dly_r      <= dly_nxt;
    per_r      <= per_nxt;
    sum_r      <= sum_nxt;
    sum_hit_r  <= sum_hit_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    ins_r      <= ins_nxt;
    disp_r     <= disp_nxt;
    fired_r    <= fired_nxt;
    ftask_r    <= ftask_nxt;
    dropped_r  <= dropped_nxt;
    lost_r     <= lost_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assert property (@(posedge clk) disable iff (!rst_n) start && !busy |=> busy)
    else $error("accepted command did not make the block busy");

  assert property (@(posedge clk) disable iff (!rst_n) count_r <= FULL)
    else $error("fill count beyond table size");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.add_dropped && out_data.tail_lost))
    else $error("add both dropped and lost the tail");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.list_empty |-> !out_data.head_ready)
    else $error("empty list reports a ready head");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r) == S_FIN_CHK)
    else $error("result strobe outside the finish step");

endmodule

FILE: hw/rtl/dlts_ram.sv
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read
module dlts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/dlts_alu.sv
`timescale 1ns / 1ps
// shared add/subtract unit with compare against the requested delay
module dlts_alu
  import dlts_pkg::*;
(
  input  alu_op_t     op,
  input  logic [16:0] a,
  input  logic [16:0] b,
  input  logic [15:0] lim,
  output logic [16:0] res,
  output logic        gt_lim
);

  always_comb begin
    case (op)
      ALU_ADD: res = a + b;
      ALU_SUB: res = a - b;
      default: res = a + b;
    endcase
    gt_lim = res > {1'b0, lim};
  end

endmodule
